>>> sv/ktsa_pkg.sv
// ktsa_pkg: shared constants, types and helpers for the keyed top-k accumulator.
// No dependencies.
package ktsa_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic signed [39:0] SIG_BOUND = 40'sh7FFFFFFF00;
  localparam logic signed [39:0] C40_MAX = 40'sh7FFFFFFFFF;
  localparam logic signed [39:0] C40_MIN = 40'sh8000000000;
  localparam logic signed [55:0] T56_MAX = 56'sh7FFFFFFFFFFFFF;
  localparam logic signed [55:0] T56_MIN = 56'sh80000000000000;

  localparam logic signed [31:0] TRK_RST = -32'sd2;
  localparam logic signed [31:0] HIT_RST = -32'sd1;

  typedef struct packed {
    logic signed [31:0] trk;
    logic signed [31:0] hit;
    logic signed [39:0] chg;
  } entry_t;

  localparam entry_t ENTRY_RST = '{trk: TRK_RST, hit: HIT_RST, chg: 40'sd0};

  function automatic logic signed [39:0] sat_sig(input logic signed [39:0] v);
    logic signed [39:0] r;
    r = v;
    if (v > SIG_BOUND) r = SIG_BOUND;
    if (v < -SIG_BOUND) r = -SIG_BOUND;
    return r;
  endfunction

  function automatic logic signed [39:0] add40(input logic signed [39:0] a,
                                               input logic signed [39:0] b);
    logic signed [40:0] s;
    logic signed [39:0] r;
    s = 41'(a) + 41'(b);
    if (s > 41'(C40_MAX)) r = C40_MAX;
    else if (s < 41'(C40_MIN)) r = C40_MIN;
    else r = s[39:0];
    return r;
  endfunction

  function automatic logic signed [55:0] add56(input logic signed [55:0] a,
                                               input logic signed [39:0] b);
    logic signed [56:0] s;
    logic signed [55:0] r;
    s = 57'(a) + 57'(b);
    if (s > 57'(T56_MAX)) r = T56_MAX;
    else if (s < 57'(T56_MIN)) r = T56_MIN;
    else r = s[55:0];
    return r;
  endfunction

endpackage

>>> sv/ktsa_ram.sv
// ktsa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ktsa_ram #(
  parameter int DEPTH = 8,
  parameter int DW = 104
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> sv/keyed_topk_signal_accumulator.sv
// keyed_topk_signal_accumulator: top level, sequencer over the entry RAM.
// Depends on ktsa_pkg and ktsa_ram.
//
//  channel | ports                                           | dir
//  in      | in_valid in_stall in_op in_track_id in_hit_id   | request in
//          | in_charge in_read_index                         |
//  out     | out_valid out_stall out_entry_* out_total_charge | result out
//
// Clear and no-op go straight to the answer, a read reads the RAM first. An
// add scans the held entries (RAM read, then compare), decides, moves entries
// one at a time (read, then write), then places, answers and idles; a merge
// bubbles the merged entry instead. All steps share the single RAM.
// Reset clears count and total; the RAM is never cleared, since count bounds
// every read. in_stall is high from accept until the result is registered; a
// stalled result holds in out_* until taken, and the next one waits behind it.
module keyed_topk_signal_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic signed [31:0] in_track_id,
  input  logic signed [31:0] in_hit_id,
  input  logic signed [39:0] in_charge,
  input  logic [2:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_entry_count,
  output logic        out_entry_valid,
  output logic signed [31:0] out_entry_track,
  output logic signed [31:0] out_entry_hit,
  output logic signed [39:0] out_entry_charge,
  output logic signed [55:0] out_total_charge
);
  localparam int IW = ktsa_pkg::IDX_W;
  localparam int CW = ktsa_pkg::CNT_W;
  localparam int EW = $bits(ktsa_pkg::entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCANW, S_DEC, S_SHIFT, S_SHIFTW, S_PLACE,
    S_BUB, S_BUBW, S_DN, S_DNW, S_RD, S_OUT
  } state_t;

  state_t state_r;
  logic [CW-1:0] count_r;
  logic signed [55:0] total_r;
  logic [1:0] op_r;
  logic [2:0] ridx_r;
  ktsa_pkg::entry_t new_r;       // incoming entry, saturated
  logic [IW-1:0] ptr_r;          // current RAM read pointer
  logic [CW-1:0] scan_r;         // entries scanned so far
  logic found_r;
  logic [IW-1:0] fpos_r;         // highest matching slot
  logic [CW-1:0] ipos_r;         // insert position (first chg < sig)
  logic ipos_set_r;
  ktsa_pkg::entry_t last_r;      // entry at count-1 (smallest)
  ktsa_pkg::entry_t cur_r;       // merged entry being bubbled
  logic [IW-1:0] dst_r;          // shift destination

  logic we;
  logic [IW-1:0] waddr, raddr;
  ktsa_pkg::entry_t wdata, rdata;
  logic [EW-1:0] rbits;

  ktsa_ram #(.DEPTH(ktsa_pkg::ENTRIES), .DW(EW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rbits)
  );
  assign rdata = ktsa_pkg::entry_t'(rbits);

  assign in_stall = (state_r != S_IDLE);
  assign raddr = ptr_r;

  logic full;
  assign full = (count_r == CW'(ktsa_pkg::ENTRIES));

  // Write port: drive from state.
  always_comb begin
    we = 1'b0;
    waddr = dst_r;
    wdata = new_r;
    unique case (state_r)
      S_SHIFTW: begin
        we = 1'b1; waddr = dst_r; wdata = rdata;
      end
      S_PLACE: begin
        we = 1'b1; waddr = ipos_r[IW-1:0]; wdata = new_r;
      end
      S_BUBW: begin
        we = 1'b1;
        if (rdata.chg < cur_r.chg) begin
          // swap: move predecessor down, merged entry goes up
          waddr = dst_r; wdata = rdata;
        end else begin
          waddr = dst_r; wdata = cur_r;
        end
      end
      S_DNW: begin
        we = 1'b1;
        if (rdata.chg > cur_r.chg) begin
          // swap: move successor up, merged entry goes down
          waddr = dst_r; wdata = rdata;
        end else begin
          waddr = dst_r; wdata = cur_r;
        end
      end
      S_DEC: begin
        we = found_r; waddr = fpos_r; wdata = cur_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      total_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state_r != S_OUT) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_op;
          ridx_r <= in_read_index;
          new_r <= '{trk: in_track_id, hit: in_hit_id,
                     chg: ktsa_pkg::sat_sig(in_charge)};
          scan_r <= '0;
          found_r <= 1'b0;
          ipos_set_r <= 1'b0;
          ipos_r <= count_r;
          unique case (in_op)
            ktsa_pkg::OP_ADD: begin
              total_r <= ktsa_pkg::add56(total_r, ktsa_pkg::sat_sig(in_charge));
              ptr_r <= '0;
              state_r <= (count_r == '0) ? S_DEC : S_SCAN;
            end
            ktsa_pkg::OP_CLEAR: begin
              count_r <= '0; total_r <= '0; state_r <= S_OUT;
            end
            ktsa_pkg::OP_READ: begin
              ptr_r <= IW'(in_read_index);
              state_r <= S_RD;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_SCAN: state_r <= S_SCANW;  // RAM read in flight
        S_SCANW: begin
          if (rdata.trk == new_r.trk) begin
            found_r <= 1'b1; fpos_r <= ptr_r[IW-1:0];
            cur_r <= '{trk: rdata.trk, hit: rdata.hit,
                       chg: ktsa_pkg::add40(rdata.chg, new_r.chg)};
          end
          if (!ipos_set_r && !(rdata.chg >= new_r.chg)) begin
            ipos_set_r <= 1'b1; ipos_r <= scan_r;
          end
          last_r <= rdata;
          if (scan_r + CW'(1) == count_r) begin
            state_r <= S_DEC;
          end else begin
            scan_r <= scan_r + CW'(1);
            ptr_r <= ptr_r + IW'(1);
            state_r <= S_SCAN;
          end
        end
        S_DEC: begin
          if (found_r) begin
            // merged entry written back here; a negative charge moves it
            // toward the tail, any other toward the head
            if (new_r.chg[39] && (CW'(fpos_r) + CW'(1) < count_r)) begin
              dst_r <= fpos_r;
              ptr_r <= fpos_r + IW'(1);
              state_r <= S_DN;
            end else if (!new_r.chg[39] && fpos_r != '0) begin
              dst_r <= fpos_r;
              ptr_r <= fpos_r - IW'(1);
              state_r <= S_BUB;
            end else state_r <= S_OUT;
          end else if (full && !(new_r.chg > last_r.chg)) begin
            state_r <= S_OUT;            // drop the new entry
          end else begin
            if (!full) count_r <= count_r + CW'(1);
            if ((full ? CW'(ktsa_pkg::ENTRIES - 1) : count_r) == ipos_r)
              state_r <= S_PLACE;
            else begin
              dst_r <= full ? IW'(ktsa_pkg::ENTRIES - 1) : count_r[IW-1:0];
              ptr_r <= (full ? IW'(ktsa_pkg::ENTRIES - 1) : count_r[IW-1:0])
                       - IW'(1);
              state_r <= S_SHIFT;
            end
          end
        end
        S_SHIFT: state_r <= S_SHIFTW;
        S_SHIFTW: begin
          if (CW'(ptr_r) == ipos_r) state_r <= S_PLACE;
          else begin
            dst_r <= ptr_r;
            ptr_r <= ptr_r - IW'(1);
            state_r <= S_SHIFT;
          end
        end
        S_PLACE: state_r <= S_OUT;
        S_BUB: state_r <= S_BUBW;
        S_BUBW: begin
          if (rdata.chg < cur_r.chg && ptr_r != '0) begin
            dst_r <= ptr_r;
            ptr_r <= ptr_r - IW'(1);
            state_r <= S_BUB;
          end else if (rdata.chg < cur_r.chg) begin
            dst_r <= ptr_r;
            state_r <= S_PLACE;
            ipos_r <= '0;
            new_r <= cur_r;
          end else state_r <= S_OUT;
        end
        S_DN: state_r <= S_DNW;
        S_DNW: begin
          if (rdata.chg > cur_r.chg && (CW'(ptr_r) + CW'(1) < count_r)) begin
            dst_r <= ptr_r;
            ptr_r <= ptr_r + IW'(1);
            state_r <= S_DN;
          end else if (rdata.chg > cur_r.chg) begin
            dst_r <= ptr_r;
            state_r <= S_PLACE;
            ipos_r <= CW'(ptr_r);
            new_r <= cur_r;
          end else state_r <= S_OUT;
        end
        S_RD: state_r <= S_OUT;
        S_OUT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          out_entry_count <= 4'(count_r);
          out_total_charge <= total_r;
          out_entry_valid <= 1'b0;
          out_entry_track <= ktsa_pkg::TRK_RST;
          out_entry_hit <= ktsa_pkg::HIT_RST;
          out_entry_charge <= '0;
          if (op_r == ktsa_pkg::OP_READ && CW'(ridx_r) < count_r) begin
            out_entry_valid <= 1'b1;
            out_entry_track <= rdata.trk;
            out_entry_hit <= rdata.hit;
            out_entry_charge <= rdata.chg;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ktsa_pkg::ENTRIES)) else $error("count over capacity");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("accept while busy");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> (count_r == $past(count_r)
      || count_r == $past(count_r) + CW'(1) || count_r == '0))
    else $error("count jump");
  a_outq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_total_charge))
    else $error("result changed while held");
`endif
endmodule

>>> tb/tb_keyed_topk_signal_accumulator.sv
// Testbench for keyed_topk_signal_accumulator: drives add/clear/read/no-op requests,
// predicts each result with a behavioral sorted-list model and checks it.
// Depends on ktsa_pkg and the accumulator RTL.
`timescale 1ns / 100ps

module tb_keyed_topk_signal_accumulator;

  // Operation code that the block must treat as a no-op.
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int N_RANDOM = 1130;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] trk;
    logic signed [31:0] hit;
    logic signed [39:0] chg;
    logic [2:0]         idx;
  } request_t;

  typedef struct {
    logic [3:0]         cnt;
    logic               vld;
    logic signed [31:0] trk;
    logic signed [31:0] hit;
    logic signed [39:0] chg;
    logic signed [55:0] tot;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = '0;
  logic signed [31:0] in_track_id = '0;
  logic signed [31:0] in_hit_id = '0;
  logic signed [39:0] in_charge = '0;
  logic [2:0] in_read_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_entry_count;
  logic out_entry_valid;
  logic signed [31:0] out_entry_track;
  logic signed [31:0] out_entry_hit;
  logic signed [39:0] out_entry_charge;
  logic signed [55:0] out_total_charge;

  keyed_topk_signal_accumulator DUT (.*);

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int error_count = 0;
  int accepted_count = 0;
  int answered_count = 0;
  int cycle_count = 0;
  bit quiet_tail = 1'b0;    // no idling near the end
  bit hold_receiver = 1'b0; // long receiver hold-off request
  bit sender_pause = 1'b0;  // sender drains before going on
  int send_gap = 0;
  int recv_gap = 0;
  // Handshake state sampled at the rising edge, used by the driver afterwards.
  logic in_stall_q = 1'b1;

  // Behavioral copy of the list state.
  logic [3:0]         list_count;
  logic signed [31:0] list_trk[ktsa_pkg::ENTRIES];
  logic signed [31:0] list_hit[ktsa_pkg::ENTRIES];
  logic signed [39:0] list_chg[ktsa_pkg::ENTRIES];
  logic signed [55:0] list_total;

  function automatic void clear_list();
    for (int i = 0; i < ktsa_pkg::ENTRIES; i++) begin
      list_trk[i] = ktsa_pkg::TRK_RST;
      list_hit[i] = ktsa_pkg::HIT_RST;
      list_chg[i] = '0;
    end
    list_count = '0;
    list_total = '0;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Fold one charge into the list: merge on matching track, else insert.
  function automatic void accumulate_charge(request_t r);
    longint s;
    int pos, last, j;
    logic signed [31:0] tt, th;
    logic signed [39:0] tc;
    bit merged;
    merged = 1'b0;
    s = clip(longint'(r.chg), -longint'(ktsa_pkg::SIG_BOUND),
             longint'(ktsa_pkg::SIG_BOUND));
    list_total = 56'(clip(longint'(list_total) + s, longint'(ktsa_pkg::T56_MIN),
                          longint'(ktsa_pkg::T56_MAX)));
    for (int i = int'(list_count) - 1; i >= 0; i--) begin
      if (!merged && list_trk[i] == r.trk) begin
        list_chg[i] = 40'(clip(longint'(list_chg[i]) + s, longint'(ktsa_pkg::C40_MIN),
                               longint'(ktsa_pkg::C40_MAX)));
        merged = 1'b1;
      end
    end
    if (merged) begin
      for (int i = 1; i < int'(list_count); i++) begin
        j = i;
        while (j > 0 && list_chg[j] > list_chg[j-1]) begin
          tt = list_trk[j]; th = list_hit[j]; tc = list_chg[j];
          list_trk[j] = list_trk[j-1]; list_hit[j] = list_hit[j-1];
          list_chg[j] = list_chg[j-1];
          list_trk[j-1] = tt; list_hit[j-1] = th; list_chg[j-1] = tc;
          j--;
        end
      end
      return;
    end
    if (int'(list_count) >= ktsa_pkg::ENTRIES &&
        s <= longint'(list_chg[ktsa_pkg::ENTRIES-1])) return;
    pos = 0;
    while (pos < int'(list_count) && longint'(list_chg[pos]) >= s) pos++;
    last = (int'(list_count) < ktsa_pkg::ENTRIES) ? int'(list_count)
                                                  : ktsa_pkg::ENTRIES - 1;
    for (j = last; j > pos; j--) begin
      list_trk[j] = list_trk[j-1];
      list_hit[j] = list_hit[j-1];
      list_chg[j] = list_chg[j-1];
    end
    list_trk[pos] = r.trk;
    list_hit[pos] = r.hit;
    list_chg[pos] = 40'(s);
    if (int'(list_count) < ktsa_pkg::ENTRIES) list_count++;
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    a.vld = 1'b0; a.trk = ktsa_pkg::TRK_RST; a.hit = ktsa_pkg::HIT_RST; a.chg = '0;
    case (r.op)
      ktsa_pkg::OP_ADD: accumulate_charge(r);
      ktsa_pkg::OP_CLEAR: clear_list();
      ktsa_pkg::OP_READ: begin
        if (r.idx < list_count) begin
          a.vld = 1'b1;
          a.trk = list_trk[r.idx];
          a.hit = list_hit[r.idx];
          a.chg = list_chg[r.idx];
        end
      end
      default: ;
    endcase
    a.cnt = list_count;
    a.tot = list_total;
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("mismatch on result %0d: %s got %0h want %0h", answered_count, what, got,
             want);
  endtask

  function automatic void push_request(logic [1:0] op, logic signed [31:0] trk,
                                       logic signed [31:0] hit,
                                       logic signed [39:0] chg, logic [2:0] idx);
    request_t r;
    r.op = op; r.trk = trk; r.hit = hit; r.chg = chg; r.idx = idx;
    pending_requests.push_back(r);
  endfunction

  // Random charge: mostly small, sometimes full width to hit saturation.
  function automatic logic signed [39:0] rand_charge();
    case ($urandom_range(0, 9))
      0: return 40'({$urandom, $urandom});
      1: return $urandom_range(0, 1) ? ktsa_pkg::C40_MAX : ktsa_pkg::C40_MIN;
      2: return $urandom_range(0, 1) ? ktsa_pkg::SIG_BOUND : -ktsa_pkg::SIG_BOUND;
      default: return 40'($signed(32'($urandom_range(0, 8000)) - 32'sd4000));
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: offer the head of the queue at the falling edge, drop it once taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_q) begin
        void'(pending_requests.pop_front());
      end
      if (in_valid && in_stall_q) begin
        // hold the stalled request
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (sender_pause && expected_answers.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   (quiet_tail || $urandom_range(0, 5) != 0)) begin
        in_valid <= 1'b1;
        in_op <= pending_requests[0].op;
        in_track_id <= pending_requests[0].trk;
        in_hit_id <= pending_requests[0].hit;
        in_charge <= pending_requests[0].chg;
        in_read_index <= pending_requests[0].idx;
      end else begin
        in_valid <= 1'b0;
        if (!quiet_tail && pending_requests.size() != 0) send_gap <= $urandom_range(0, 2);
      end
      // receiver idling in bursts
      if (hold_receiver) out_stall <= 1'b1;
      else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_stall_q <= !(in_valid && !in_stall);
    if (rst_n && in_valid && !in_stall) begin
      expected_answers.push_back(predict_answer(pending_requests[0]));
      accepted_count <= accepted_count + 1;
    end
  end

  // Monitor: compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && !out_stall) begin
      answered_count <= answered_count + 1;
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        e = expected_answers.pop_front();
        if (out_entry_count !== e.cnt) report_mismatch("count", out_entry_count, e.cnt);
        if (out_entry_valid !== e.vld) report_mismatch("valid", out_entry_valid, e.vld);
        if (out_entry_track !== e.trk) report_mismatch("track", out_entry_track, e.trk);
        if (out_entry_hit !== e.hit) report_mismatch("hit", out_entry_hit, e.hit);
        if (out_entry_charge !== e.chg)
          report_mismatch("charge", out_entry_charge, e.chg);
        if (out_total_charge !== e.tot)
          report_mismatch("total", out_total_charge, e.tot);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] base;
    clear_list();
    // Directed: extremes, every op, saturation, merge, full-list drop.
    push_request(ktsa_pkg::OP_READ, 0, 0, 40'sd0, 3'd0);
    push_request(ktsa_pkg::OP_ADD, 32'sh7FFFFFFF, 32'sh80000000, ktsa_pkg::C40_MAX, 3'd7);
    push_request(ktsa_pkg::OP_ADD, 32'sh80000000, 32'sh7FFFFFFF, ktsa_pkg::C40_MIN, 3'd0);
    push_request(ktsa_pkg::OP_ADD, 5, 1, ktsa_pkg::SIG_BOUND, 3'd0);
    push_request(ktsa_pkg::OP_ADD, 5, 2, ktsa_pkg::SIG_BOUND, 3'd0); // merge saturates
    push_request(ktsa_pkg::OP_ADD, 6, 3, -ktsa_pkg::SIG_BOUND, 3'd0);
    push_request(OP_NONE, -1, -1, -40'sd1, 3'd7);
    for (int i = 0; i < 8; i++) push_request(ktsa_pkg::OP_ADD, 100 + i, i, 40'(256 * i), 3'd0);
    push_request(ktsa_pkg::OP_ADD, 200, 9, -40'sd1000, 3'd0);   // discarded when full
    push_request(ktsa_pkg::OP_ADD, 201, 9, 40'sd100000, 3'd0);  // drops the smallest
    push_request(ktsa_pkg::OP_ADD, 101, 9, 40'sd999999, 3'd0);  // track not held, so inserted; drops the smallest
    for (int i = 0; i < 8; i++) push_request(ktsa_pkg::OP_READ, 0, 0, 40'sd0, 3'(i));
    push_request(ktsa_pkg::OP_CLEAR, 0, 0, 40'sd0, 3'd0);
    push_request(ktsa_pkg::OP_READ, 0, 0, 40'sd0, 3'd0);
    // Random: mostly a small track pool so merges are frequent.
    for (int i = 0; i < N_RANDOM; i++) begin
      base = $urandom_range(0, 3) == 0 ? 32'($urandom) : 32'($urandom_range(0, 11));
      case ($urandom_range(0, 19))
        0: push_request(ktsa_pkg::OP_CLEAR, 32'($urandom), 32'($urandom), rand_charge(),
                        3'($urandom));
        1: push_request(OP_NONE, 32'($urandom), 32'($urandom), rand_charge(),
                        3'($urandom));
        2, 3, 4, 5: push_request(ktsa_pkg::OP_READ, 32'($urandom), 32'($urandom),
                                 rand_charge(), 3'($urandom));
        default: push_request(ktsa_pkg::OP_ADD, base, 32'($urandom), rand_charge(),
                              3'($urandom));
      endcase
    end
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // Long receiver hold-off so the block backs up and stalls its input.
    wait (accepted_count > 300);
    @(negedge clk) hold_receiver <= 1'b1;
    repeat (200) @(posedge clk);
    @(negedge clk) hold_receiver <= 1'b0;
    // Sender pauses until every result is back.
    wait (accepted_count > 600);
    @(negedge clk) sender_pause <= 1'b1;
    wait (expected_answers.size() == 0);
    @(negedge clk) sender_pause <= 1'b0;
    wait (pending_requests.size() < 150);
    @(negedge clk) quiet_tail <= 1'b1;
    wait (pending_requests.size() == 0 && expected_answers.size() == 0);
    repeat (60) @(posedge clk);
    $display("covered %0d requests (adds, merges, clears, reads, no-ops), %0d results",
             accepted_count, answered_count);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> keyed_topk_signal_accumulator.f
sv/ktsa_pkg.sv
sv/ktsa_ram.sv
sv/keyed_topk_signal_accumulator.sv
tb/tb_keyed_topk_signal_accumulator.sv
